// ===== rtl/core/svpc_pkg.sv =====
// shared types, constants and helpers for the scheduled vent position controller
package svpc_pkg;

  localparam int NUM_ENTRIES = 8;
  localparam int STEP_SIZE   = 10;
  localparam int ROUTE_BITS  = 16;

  localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int NUM_W = $clog2(NUM_ENTRIES + 1);
  localparam int RW1   = ROUTE_BITS + 1;

  localparam int SEC_W  = 17;
  localparam int MIN_W  = 11;
  localparam int TEMP_W = 12;
  localparam int BAND_W = 8;

  localparam logic [SEC_W-1:0] DAY_LAST_SECOND = SEC_W'(86399);
  localparam logic [SEC_W:0]   DAY_SECONDS     = (SEC_W+1)'(86400);
  localparam logic [MIN_W-1:0] DAY_MINUTES     = MIN_W'(1440);

  // seconds to minutes: (s * MIN_RECIP) >> MIN_SHIFT is exact for s < 86400
  localparam int MIN_RECIP_W = 18;
  localparam logic [MIN_RECIP_W-1:0] MIN_RECIP = MIN_RECIP_W'(139811);
  localparam int MIN_SHIFT = 23;
  localparam int PROD_W    = SEC_W + MIN_RECIP_W;

  // motor drive codes
  localparam logic [1:0] DRV_STOP = 2'd0;
  localparam logic [1:0] DRV_FWD  = 2'd1;
  localparam logic [1:0] DRV_REV  = 2'd2;

  // temperature step codes
  localparam logic [1:0] STEP_NONE = 2'd0;
  localparam logic [1:0] STEP_UP   = 2'd1;
  localparam logic [1:0] STEP_DOWN = 2'd2;

  // item kinds and entry kinds
  localparam logic REQ_TICK   = 1'b0;
  localparam logic REQ_WRITE  = 1'b1;
  localparam logic KIND_ROUTE = 1'b0;
  localparam logic KIND_TEMP  = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_MANUAL    = 2'd0;
  localparam logic [1:0] REG_DELAY     = 2'd1;
  localparam logic [1:0] REG_MAX_ROUTE = 2'd2;

  typedef struct packed {
    logic                    open;
    logic                    kind;
    logic [MIN_W-1:0]        start;
    logic [ROUTE_BITS-1:0]   route;
    logic signed [BAND_W-1:0] hi;
    logic signed [BAND_W-1:0] lo;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  function automatic entry_t reset_entry(input logic [IDX_W-1:0] idx);
    entry_t e;
    e.open  = (idx == '0);
    e.kind  = KIND_ROUTE;
    e.start = (idx == '0) ? MIN_W'(240) : MIN_W'(1439);
    e.route = '0;
    e.hi    = BAND_W'(25);
    e.lo    = BAND_W'(20);
    return e;
  endfunction

endpackage

// ===== rtl/core/scheduled_vent_position_controller.sv =====
// scheduled vent position controller: schedule memory, scan sequencer and motor logic
// A tick item scans the whole schedule and is then evaluated and applied: the schedule lives
// in one memory with a single registered read port, so the scan reads one entry per cycle,
// then the active entry is read once more, evaluated and applied. A write item or a tick in
// manual mode skips the scan and goes straight to the output stage. The schedule comes out
// of reset already holding its default entries, with no clearing pass. One item is in
// work at a time; a finished result waits in the output register while the next item is
// accepted, and a result not yet taken holds the next one back until it is.
module scheduled_vent_position_controller
  import svpc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [3:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      req_type,
  input  logic [2:0]                entry_index,
  input  logic                      entry_open,
  input  logic                      entry_kind,
  input  logic [MIN_W-1:0]          entry_start_minute,
  input  logic [ROUTE_BITS-1:0]     entry_route,
  input  logic signed [BAND_W-1:0]  entry_temp_high,
  input  logic signed [BAND_W-1:0]  entry_temp_low,
  input  logic [SEC_W-1:0]          time_of_day,
  input  logic [ROUTE_BITS-1:0]     current_route,
  input  logic signed [TEMP_W-1:0]  temperature_tenths,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                motor_drive,
  output logic [3:0]                active_entry,
  output logic                      drive_changed
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_LAST  = 3'd2;
  localparam logic [2:0] ST_RDA   = 3'd3;
  localparam logic [2:0] ST_EVAL  = 3'd4;
  localparam logic [2:0] ST_APPLY = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0] state;

  // configuration
  logic                  manual_hold;
  logic [SEC_W-1:0]      inspection_delay;
  logic [ROUTE_BITS-1:0] max_route;
  logic                  cfg_we;

  // schedule memory
  logic [ENTRY_W-1:0] mem [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0] entry_valid;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  entry_t             mem_wdata;
  logic [IDX_W-1:0]   raddr;
  logic [ENTRY_W-1:0] rd_raw;
  logic               rd_valid;
  logic [IDX_W-1:0]   rd_idx;
  entry_t             rd_entry;

  // controller state
  logic [NUM_W-1:0]      active;
  logic [IDX_W-1:0]      active_idx;
  logic [1:0]            drive;
  logic                  timer_armed;
  logic [SEC_W-1:0]      timer_start;
  logic [1:0]            step_mode;
  logic [ROUTE_BITS-1:0] step_origin;

  // item in work
  logic [SEC_W-1:0]         now_s;
  logic [ROUTE_BITS-1:0]    cur;
  logic signed [TEMP_W-1:0] temp;
  logic [MIN_W-1:0]         minute;
  logic [PROD_W-1:0]        prod;
  logic [NUM_W-1:0]         scan_cnt;
  entry_t                   prev;
  logic                     changed;

  // evaluation flags
  logic a_kind, gt, lt, eq, elapsed_ok, hot, cold, up_done, dn_done;
  logic [SEC_W-1:0]         ts_eff;
  logic [SEC_W:0]           elapsed_w;
  logic signed [TEMP_W:0]   hi10, lo10, temp_x;
  logic [ROUTE_BITS-1:0]    stop_at;

  // apply results
  logic [1:0]            drive_next;
  logic [1:0]            step_mode_next;
  logic                  timer_armed_next;
  logic [SEC_W-1:0]      timer_start_next;
  logic [ROUTE_BITS-1:0] step_origin_next;
  logic                  new_step;

  logic in_fire;
  logic match_prev, match_last;

  assign pready   = 1'b1;
  assign cfg_we   = psel && penable && pwrite && pready;
  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      manual_hold      <= 1'b0;
      inspection_delay <= SEC_W'(60);
      max_route        <= ROUTE_BITS'(1000);
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        REG_MANUAL:    manual_hold      <= pwdata[0];
        REG_DELAY:     inspection_delay <= pwdata[SEC_W-1:0];
        REG_MAX_ROUTE: max_route        <= pwdata[ROUTE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_MANUAL:    prdata = {31'd0, manual_hold};
      REG_DELAY:     prdata = 32'(inspection_delay);
      REG_MAX_ROUTE: prdata = 32'(max_route);
      default:       prdata = '0;
    endcase
  end

  // schedule writes happen only at acceptance, never during a scan
  assign mem_we    = in_fire && (req_type == REQ_WRITE) && (32'(entry_index) < NUM_ENTRIES);
  assign mem_waddr = IDX_W'(entry_index);
  always_comb begin
    mem_wdata.open  = entry_open;
    mem_wdata.kind  = entry_kind;
    mem_wdata.start = entry_start_minute;
    mem_wdata.route = entry_route;
    mem_wdata.hi    = entry_temp_high;
    mem_wdata.lo    = entry_temp_low;
  end

  assign active_idx = IDX_W'(active - NUM_W'(1));
  assign raddr      = (state == ST_SCAN) ? scan_cnt[IDX_W-1:0] : active_idx;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_raw <= mem[raddr];
    rd_idx <= raddr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      rd_valid    <= 1'b0;
    end else begin
      if (mem_we) begin
        entry_valid[mem_waddr] <= 1'b1;
      end
      rd_valid <= entry_valid[raddr];
    end
  end

  assign rd_entry = rd_valid ? entry_t'(rd_raw) : reset_entry(rd_idx);

  assign prod = PROD_W'(now_s) * PROD_W'(MIN_RECIP);

  assign match_prev = prev.open && (minute >= prev.start) && (minute < rd_entry.start);
  assign match_last = prev.open && (minute >= prev.start) && (minute < DAY_MINUTES);

  // evaluation terms on the active entry
  assign ts_eff    = timer_armed ? timer_start : now_s;
  assign elapsed_w = (now_s >= ts_eff) ? {1'b0, now_s - ts_eff}
                                       : ({1'b0, now_s} + DAY_SECONDS - {1'b0, ts_eff});
  assign temp_x    = {temp[TEMP_W-1], temp};
  assign hi10      = ((TEMP_W+1)'(rd_entry.hi) <<< 3) + ((TEMP_W+1)'(rd_entry.hi) <<< 1);
  assign lo10      = ((TEMP_W+1)'(rd_entry.lo) <<< 3) + ((TEMP_W+1)'(rd_entry.lo) <<< 1);
  assign stop_at   = ({1'b0, step_origin} > RW1'(STEP_SIZE))
                     ? step_origin - ROUTE_BITS'(STEP_SIZE) : '0;

  always_comb begin
    drive_next       = drive;
    step_mode_next   = step_mode;
    timer_armed_next = timer_armed;
    timer_start_next = timer_start;
    step_origin_next = step_origin;
    new_step         = 1'b0;
    if (a_kind == KIND_ROUTE) begin
      if (gt && drive == DRV_STOP) begin
        drive_next = DRV_REV;
      end else if (lt && drive == DRV_STOP) begin
        drive_next = DRV_FWD;
      end else if (eq && drive != DRV_STOP) begin
        drive_next = DRV_STOP;
      end
    end else begin
      if (!timer_armed) begin
        timer_start_next = now_s;
        timer_armed_next = 1'b1;
      end
      if (elapsed_ok) begin
        if (drive == DRV_STOP) begin
          if (hot) begin
            step_origin_next = cur;
            step_mode_next   = STEP_UP;
            drive_next       = DRV_FWD;
            new_step         = 1'b1;
          end else if (cold) begin
            step_origin_next = cur;
            step_mode_next   = STEP_DOWN;
            drive_next       = DRV_REV;
            new_step         = 1'b1;
          end
        end
        timer_start_next = now_s;
      end
    end
    // a step started on this tick cannot already be complete
    if (step_mode_next != STEP_NONE) begin
      timer_start_next = now_s;
      if (!new_step && ((step_mode_next == STEP_UP && up_done) ||
                        (step_mode_next == STEP_DOWN && dn_done))) begin
        timer_armed_next = 1'b0;
        step_mode_next   = STEP_NONE;
        drive_next       = DRV_STOP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      active      <= NUM_W'(1);
      drive       <= DRV_STOP;
      timer_armed <= 1'b0;
      timer_start <= '0;
      step_mode   <= STEP_NONE;
      step_origin <= '0;
      scan_cnt    <= '0;
      changed     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            now_s    <= (time_of_day > DAY_LAST_SECOND) ? DAY_LAST_SECOND : time_of_day;
            cur      <= current_route;
            temp     <= temperature_tenths;
            scan_cnt <= '0;
            changed  <= 1'b0;
            if (req_type == REQ_TICK && !manual_hold) begin
              state <= ST_SCAN;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_SCAN: begin
          if (scan_cnt == '0) begin
            minute <= prod[MIN_SHIFT +: MIN_W];
          end
          if (scan_cnt >= NUM_W'(2) && match_prev) begin
            active <= scan_cnt - NUM_W'(1);
          end
          if (scan_cnt != '0) begin
            prev <= rd_entry;
          end
          if (scan_cnt == NUM_W'(NUM_ENTRIES)) begin
            state <= ST_LAST;
          end else begin
            scan_cnt <= scan_cnt + NUM_W'(1);
          end
        end
        ST_LAST: begin
          if (match_last) begin
            active <= NUM_W'(NUM_ENTRIES);
          end
          state <= ST_RDA;
        end
        ST_RDA: begin
          state <= ST_EVAL;
        end
        ST_EVAL: begin
          a_kind     <= rd_entry.kind;
          gt         <= cur > rd_entry.route;
          lt         <= cur < rd_entry.route;
          eq         <= cur == rd_entry.route;
          elapsed_ok <= elapsed_w[SEC_W-1:0] >= inspection_delay;
          hot        <= (temp_x > hi10) && (cur < max_route);
          cold       <= (temp_x < lo10) && (cur != '0);
          up_done    <= {1'b0, cur} >= ({1'b0, step_origin} + RW1'(STEP_SIZE));
          dn_done    <= cur <= stop_at;
          state      <= ST_APPLY;
        end
        ST_APPLY: begin
          drive       <= drive_next;
          step_mode   <= step_mode_next;
          timer_armed <= timer_armed_next;
          timer_start <= timer_start_next;
          step_origin <= step_origin_next;
          changed     <= (drive_next != drive);
          state       <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid     <= 1'b1;
            motor_drive   <= drive;
            active_entry  <= 4'(active);
            drive_changed <= changed;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_active_range: assert property (@(posedge clk) disable iff (rst)
    (active >= NUM_W'(1)) && (active <= NUM_W'(NUM_ENTRIES)))
    else $error("active entry out of range");

  a_drive_code: assert property (@(posedge clk) disable iff (rst)
    (drive == DRV_STOP) || (drive == DRV_FWD) || (drive == DRV_REV))
    else $error("illegal motor drive code");

  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == ST_IDLE))
    else $error("schedule write during a scan");

  a_scan_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LAST) |=> (state == ST_RDA))
    else $error("sequencer left the scan out of order");

endmodule

// ===== verif/svpc_checker.sv =====
// checker for the scheduled vent position controller: tracks the schedule, predicts and compares
module svpc_checker
  import svpc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [3:0]               paddr,
  input  logic [31:0]              pwdata,
  input  logic                     pready,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic                     req_type,
  input  logic [2:0]               entry_index,
  input  logic                     entry_open,
  input  logic                     entry_kind,
  input  logic [MIN_W-1:0]         entry_start_minute,
  input  logic [ROUTE_BITS-1:0]    entry_route,
  input  logic signed [BAND_W-1:0] entry_temp_high,
  input  logic signed [BAND_W-1:0] entry_temp_low,
  input  logic [SEC_W-1:0]         time_of_day,
  input  logic [ROUTE_BITS-1:0]    current_route,
  input  logic signed [TEMP_W-1:0] temperature_tenths,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic [1:0]               motor_drive,
  input  logic [3:0]               active_entry,
  input  logic                     drive_changed,
  output int                       outstanding,
  output int                       failures
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0] drive;
    logic [3:0] entry;
    logic       changed;
  } vent_report_t;

  entry_t                plan [NUM_ENTRIES];
  logic [3:0]            cur_entry;
  logic [1:0]            drive;
  logic                  armed;
  logic [SEC_W-1:0]      check_from;
  logic [1:0]            step;
  logic [ROUTE_BITS-1:0] step_from;
  logic                  manual;
  logic [SEC_W-1:0]      delay_s;
  logic [ROUTE_BITS-1:0] route_limit;
  vent_report_t          due [$];
  vent_report_t          want;
  int                    errors = 0;

  function automatic vent_report_t run_tick(input logic [SEC_W-1:0] tod,
                                            input logic [ROUTE_BITS-1:0] pos,
                                            input logic signed [TEMP_W-1:0] temp_in);
    logic [SEC_W-1:0] now_s;
    int unsigned      now_m, next_m, elapsed, stop_at;
    int               temp, hi10, lo10;
    entry_t           e;
    logic [1:0]       was;
    vent_report_t     rep;
    was = drive;
    now_s = (tod > DAY_LAST_SECOND) ? DAY_LAST_SECOND : tod;
    now_m = now_s / 60;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      if (i + 1 < NUM_ENTRIES) begin
        next_m = 32'(plan[i + 1].start);
      end else begin
        next_m = 1440;
      end
      if (plan[i].open && now_m >= plan[i].start && now_m < next_m) begin
        cur_entry = 4'(i + 1);
      end
    end
    e = plan[IDX_W'(cur_entry - 4'd1)];
    if (e.kind == KIND_ROUTE) begin
      if (pos > e.route && drive == DRV_STOP) begin
        drive = DRV_REV;
      end else if (pos < e.route && drive == DRV_STOP) begin
        drive = DRV_FWD;
      end else if (pos == e.route && drive != DRV_STOP) begin
        drive = DRV_STOP;
      end
    end else begin
      if (!armed) begin
        check_from = now_s;
        armed = 1'b1;
      end
      // elapsed time wraps at midnight
      elapsed = (now_s >= check_from) ? now_s - check_from : now_s + 86400 - check_from;
      if (elapsed >= delay_s) begin
        temp = int'(temp_in);
        hi10 = 10 * $signed(e.hi);
        lo10 = 10 * $signed(e.lo);
        if (drive == DRV_STOP) begin
          if (temp > hi10 && pos < route_limit) begin
            step_from = pos;
            step = STEP_UP;
            drive = DRV_FWD;
          end else if (temp < lo10 && pos > 0) begin
            step_from = pos;
            step = STEP_DOWN;
            drive = DRV_REV;
          end
        end
        check_from = now_s;
      end
    end
    if (step == STEP_UP) begin
      check_from = now_s;
      if (int'(pos) >= int'(step_from) + STEP_SIZE) begin
        armed = 1'b0;
        step = STEP_NONE;
        drive = DRV_STOP;
      end
    end else if (step == STEP_DOWN) begin
      // closing step stops at zero at the lowest
      stop_at = (step_from > STEP_SIZE) ? step_from - STEP_SIZE : 0;
      check_from = now_s;
      if (pos <= stop_at) begin
        armed = 1'b0;
        step = STEP_NONE;
        drive = DRV_STOP;
      end
    end
    rep.drive = drive;
    rep.entry = cur_entry;
    rep.changed = (drive != was);
    return rep;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        plan[i].open = (i == 0);
        plan[i].kind = KIND_ROUTE;
        plan[i].start = (i == 0) ? MIN_W'(240) : MIN_W'(1439);
        plan[i].route = '0;
        plan[i].hi = BAND_W'(25);
        plan[i].lo = BAND_W'(20);
      end
      cur_entry = 4'd1;
      drive = DRV_STOP;
      armed = 1'b0;
      check_from = '0;
      step = STEP_NONE;
      step_from = '0;
      manual = 1'b0;
      delay_s = SEC_W'(60);
      route_limit = ROUTE_BITS'(1000);
      due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_MANUAL: manual = pwdata[0];
          REG_DELAY: delay_s = pwdata[SEC_W-1:0];
          REG_MAX_ROUTE: route_limit = pwdata[ROUTE_BITS-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (req_type == REQ_WRITE) begin
          if (entry_index < NUM_ENTRIES) begin
            plan[entry_index] = '{open: entry_open, kind: entry_kind,
                                  start: entry_start_minute, route: entry_route,
                                  hi: entry_temp_high, lo: entry_temp_low};
          end
          due.push_back('{drive: drive, entry: cur_entry, changed: 1'b0});
        end else if (manual) begin
          due.push_back('{drive: drive, entry: cur_entry, changed: 1'b0});
        end else begin
          due.push_back(run_tick(time_of_day, current_route, temperature_tenths));
        end
      end
      if (out_valid && out_ready) begin
        if (due.size() == 0) begin
          $error("result with no item waiting: motor_drive %0d active_entry %0d",
                 motor_drive, active_entry);
          errors++;
        end else begin
          want = due.pop_front();
          if (motor_drive !== want.drive) begin
            $error("motor_drive expected %0d got %0d", want.drive, motor_drive);
            errors++;
          end
          if (active_entry !== want.entry) begin
            $error("active_entry expected %0d got %0d", want.entry, active_entry);
            errors++;
          end
          if (drive_changed !== want.changed) begin
            $error("drive_changed expected %0d got %0d", want.changed, drive_changed);
            errors++;
          end
        end
      end
    end
    outstanding <= due.size();
    failures <= errors;
  end

endmodule

// ===== verif/testbench.sv =====
// top of the vent controller testbench: clock, reset, stimulus, configuration and verdict
module testbench
  import svpc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT  = 1000000;
  localparam int SETTLE = 30;

  typedef struct {
    logic                     req;
    logic [2:0]               idx;
    logic                     en;
    logic                     kind;
    logic [MIN_W-1:0]         start;
    logic [ROUTE_BITS-1:0]    route;
    logic signed [BAND_W-1:0] hi;
    logic signed [BAND_W-1:0] lo;
    logic [SEC_W-1:0]         tod;
    logic [ROUTE_BITS-1:0]    pos;
    logic signed [TEMP_W-1:0] temp;
  } vent_item_t;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     psel, penable, pwrite;
  logic [3:0]               paddr;
  logic [31:0]              pwdata, prdata;
  logic                     pready;
  logic                     in_valid, in_ready;
  logic                     req_type;
  logic [2:0]               entry_index;
  logic                     entry_open, entry_kind;
  logic [MIN_W-1:0]         entry_start_minute;
  logic [ROUTE_BITS-1:0]    entry_route;
  logic signed [BAND_W-1:0] entry_temp_high, entry_temp_low;
  logic [SEC_W-1:0]         time_of_day;
  logic [ROUTE_BITS-1:0]    current_route;
  logic signed [TEMP_W-1:0] temperature_tenths;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [1:0]               motor_drive;
  logic [3:0]               active_entry;
  logic                     drive_changed;
  int                       outstanding, failures;

  int                       cycles = 0;
  int                       hold_left = 0;
  int                       pick;
  logic                     quiet = 1'b0;
  logic [1:0]               seen_drive = DRV_STOP;
  int                       vent_pos = 0;
  int                       clock_s = 0;
  int                       targets [NUM_ENTRIES];

  scheduled_vent_position_controller dut (.*);

  svpc_checker watch (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else begin
      pick = $urandom_range(0, 99);
      if (quiet || pick < 60) begin
        out_ready <= 1'b1;
        hold_left <= $urandom_range(0, 12);
      end else if (pick < 94) begin
        out_ready <= 1'b0;
        hold_left <= $urandom_range(0, 3);
      end else begin
        out_ready <= 1'b0;
        hold_left <= $urandom_range(15, 60);
      end
    end
    if (out_valid && out_ready) seen_drive <= motor_drive;
  end

  task automatic apb_write(input logic [1:0] reg_idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_controls(input logic manual, input int delay, input int max_pos);
    apb_write(REG_MANUAL, {31'd0, manual});
    apb_write(REG_DELAY, 32'(delay));
    apb_write(REG_MAX_ROUTE, 32'(max_pos));
  endtask

  task automatic send(input vent_item_t it);
    int r, gap;
    in_valid <= 1'b1;
    req_type <= it.req;
    entry_index <= it.idx;
    entry_open <= it.en;
    entry_kind <= it.kind;
    entry_start_minute <= it.start;
    entry_route <= it.route;
    entry_temp_high <= it.hi;
    entry_temp_low <= it.lo;
    time_of_day <= it.tod;
    current_route <= it.pos;
    temperature_tenths <= it.temp;
    do @(posedge clk); while (!in_ready);
    r = $urandom_range(0, 99);
    gap = 0;
    if (!quiet) begin
      if (r >= 92) gap = $urandom_range(15, 40);
      else if (r >= 55) gap = $urandom_range(1, 4);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic tick(input int tod, input int pos, input int temp);
    vent_item_t it;
    it.req = REQ_TICK;
    it.idx = 3'($urandom);
    it.en = 1'($urandom);
    it.kind = 1'($urandom);
    it.start = MIN_W'($urandom);
    it.route = ROUTE_BITS'($urandom);
    it.hi = BAND_W'($urandom);
    it.lo = BAND_W'($urandom);
    it.tod = SEC_W'(tod);
    it.pos = ROUTE_BITS'(pos);
    it.temp = TEMP_W'(temp);
    send(it);
  endtask

  task automatic load_entry(input int idx, input logic en, input logic kind, input int start,
                            input int route, input int hi, input int lo);
    vent_item_t it;
    it.req = REQ_WRITE;
    it.idx = 3'(idx);
    it.en = en;
    it.kind = kind;
    it.start = MIN_W'(start);
    it.route = ROUTE_BITS'(route);
    it.hi = BAND_W'(hi);
    it.lo = BAND_W'(lo);
    it.tod = SEC_W'($urandom);
    it.pos = ROUTE_BITS'($urandom);
    it.temp = TEMP_W'($urandom);
    send(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_random_entry(input int idx, input int start);
    int hi, lo, route;
    route = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 1200) : $urandom_range(0, 65535);
    lo = $urandom_range(0, 30);
    hi = lo + $urandom_range(0, 15);
    if ($urandom_range(0, 99) < 10) begin
      hi = $urandom_range(0, 165) - 40;
      lo = $urandom_range(0, 165) - 40;
    end
    if ($urandom_range(0, 99) < 3) begin
      hi = $urandom_range(0, 255) - 128;
      lo = $urandom_range(0, 255) - 128;
    end
    targets[idx] = route;
    load_entry(idx, $urandom_range(0, 99) < 75, $urandom_range(0, 1) ? KIND_TEMP : KIND_ROUTE,
               start, route, hi, lo);
  endtask

  task automatic load_random_schedule();
    int   starts [$];
    logic tidy;
    tidy = $urandom_range(0, 99) < 80;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      starts.push_back(tidy ? $urandom_range(0, 1439) : $urandom_range(0, 2047));
    end
    if (tidy) starts.sort();
    for (int i = 0; i < NUM_ENTRIES; i++) write_random_entry(i, starts[i]);
  endtask

  task automatic random_tick();
    int r, tod, temp;
    r = $urandom_range(0, 99);
    if (r < 70) clock_s += $urandom_range(1, 60);
    else if (r < 95) clock_s += $urandom_range(60, 900);
    else clock_s = $urandom_range(0, 86399);
    clock_s = clock_s % 86400;
    // vent follows the motor, with jumps near known targets or anywhere now and then
    if (seen_drive == DRV_FWD) vent_pos += ($urandom_range(0, 99) < 70) ? 1 : $urandom_range(2, 4);
    else if (seen_drive == DRV_REV) vent_pos -= ($urandom_range(0, 99) < 70) ? 1 : $urandom_range(2, 4);
    r = $urandom_range(0, 99);
    if (r < 8) vent_pos = targets[$urandom_range(0, NUM_ENTRIES - 1)] + $urandom_range(0, 6) - 3;
    else if (r < 11) vent_pos = $urandom_range(0, 1300);
    else if (r < 12) vent_pos = $urandom_range(0, 65535);
    if (vent_pos < 0) vent_pos = 0;
    if (vent_pos > 65535) vent_pos = 65535;
    tod = ($urandom_range(0, 99) < 3) ? $urandom_range(86400, 131071) : clock_s;
    r = $urandom_range(0, 99);
    if (r < 90) temp = $urandom_range(0, 500) - 50;
    else if (r < 97) temp = $urandom_range(0, 1650) - 400;
    else temp = $urandom_range(0, 4095) - 2048;
    tick(tod, vent_pos, temp);
  endtask

  initial begin
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_valid <= 1'b0;
    req_type <= REQ_TICK;
    entry_index <= '0;
    entry_open <= 1'b0;
    entry_kind <= KIND_ROUTE;
    entry_start_minute <= '0;
    entry_route <= '0;
    entry_temp_high <= '0;
    entry_temp_low <= '0;
    time_of_day <= '0;
    current_route <= '0;
    temperature_tenths <= '0;
    for (int i = 0; i < NUM_ENTRIES; i++) targets[i] = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset schedule: no entry matches before minute 240
    tick(0, 5, 0);
    tick(14400, 0, 0);
    load_entry(0, 1'b1, KIND_TEMP, 0, 65535, 25, 20);
    load_entry(7, 1'b1, KIND_TEMP, 1439, 0, 125, -40);
    // last entry bounded by end of day, clock past range, midnight wrap
    tick(86370, 500, 1250);
    tick(131071, 500, 1250);
    tick(40, 500, 1250);
    tick(45, 505, 1250);
    tick(46, 510, 1250);
    drain();
    set_controls(1'b0, 0, 1000);
    tick(100, 65535, 1250);
    tick(101, 65535, -400);
    tick(102, 65525, -400);
    // closing step near zero
    tick(103, 5, -400);
    tick(104, 3, -400);
    tick(105, 0, -400);
    tick(106, 0, -400);
    // position entry, ignored while moving
    load_entry(0, 1'b1, KIND_ROUTE, 0, 100, 25, 20);
    tick(200, 50, 0);
    tick(210, 200, 0);
    tick(220, 100, 0);
    // step still tracked after switching to a position entry
    load_entry(7, 1'b1, KIND_TEMP, 1439, 0, 25, -40);
    tick(86399, 0, 1250);
    tick(10, 10, 1250);
    drain();
    set_controls(1'b1, 0, 1000);
    tick(500, 7, 1250);
    drain();

    targets[0] = 100;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_controls(1'b0, 60, 1000);
        1: set_controls(1'b0, 0, 0);
        2: set_controls(1'b0, $urandom_range(1, 30), 65535);
        3: set_controls(1'b0, 86399, $urandom_range(0, 1300));
        4: set_controls(1'b0, 131071, $urandom_range(0, 1300));
        5: set_controls(1'b1, 5, 500);
        6: set_controls(1'b0, $urandom_range(0, 120), $urandom_range(0, 1300));
        default: set_controls(1'b0, $urandom_range(0, 10), $urandom_range(200, 1300));
      endcase
      quiet = (ph == 3);
      load_random_schedule();
      for (int n = 0; n < ((ph == 5) ? 60 : 200); n++) begin
        if ($urandom_range(0, 99) < 8) begin
          write_random_entry($urandom_range(0, NUM_ENTRIES - 1), $urandom_range(0, 1439));
        end else begin
          random_tick();
        end
      end
      drain();
    end

    if (failures == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// ===== scheduled_vent_position_controller.f =====
rtl/core/svpc_pkg.sv
rtl/core/scheduled_vent_position_controller.sv
verif/svpc_checker.sv
verif/testbench.sv
